[hw/rtl/lmcf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmcf_pkg
// Shared types and constants for the LED matrix cursor frame buffer.
// ----------------------------------------------------------------------------
package lmcf_pkg;

    // Frame geometry
    localparam int SIDE_DEF = 8;
    localparam int FRAME_W  = 64;

    // Point status codes
    localparam logic [1:0] ST_OFF  = 2'd0;
    localparam logic [1:0] ST_ON   = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    // Command codes
    typedef enum logic [3:0] {
        CMD_SET        = 4'd0,
        CMD_CLEAR      = 4'd1,
        CMD_TOGGLE     = 4'd2,
        CMD_GET        = 4'd3,
        CMD_LOAD       = 4'd4,
        CMD_ROTATE     = 4'd5,
        CMD_STAGE      = 4'd6,
        CMD_UNSTAGE    = 4'd7,
        CMD_TOGGLE_CUR = 4'd8,
        CMD_MOVE       = 4'd9,
        CMD_TICK       = 4'd10,
        CMD_BLINK      = 4'd11,
        CMD_BLANK      = 4'd12
    } cmd_t;

    // Cursor move directions
    localparam logic [1:0] DIR_XP = 2'd0;
    localparam logic [1:0] DIR_XN = 2'd1;
    localparam logic [1:0] DIR_YP = 2'd2;
    localparam logic [1:0] DIR_YN = 2'd3;

    // Rotation codes
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // Frame buffer and cursor state
    typedef struct packed {
        logic [FRAME_W-1:0] pixels;
        logic [3:0]         cur_x;
        logic [3:0]         cur_y;
        logic               saved;
        logic               staged;
        logic               blink;
    } state_t;

    // One registered input item
    typedef struct packed {
        logic [3:0]         cmd;
        logic [3:0]         x;
        logic [3:0]         y;
        logic [1:0]         move_dir;
        logic [1:0]         rotation;
        logic [FRAME_W-1:0] image;
    } item_t;

endpackage

[hw/rtl/lmcf_exec.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmcf_exec
// Combinational command execution: next frame/cursor state and point status.
// ----------------------------------------------------------------------------
module lmcf_exec #(
    parameter int SIDE = lmcf_pkg::SIDE_DEF
) (
    input  lmcf_pkg::state_t cur,
    input  lmcf_pkg::item_t  item,
    input  logic [1:0]       orientation,
    output lmcf_pkg::state_t nxt,
    output logic [1:0]       status
);

    localparam int          FW     = lmcf_pkg::FRAME_W;
    localparam logic [3:0]  SIDE_C = 4'(SIDE);
    localparam logic [FW-1:0] REGION = {FW{1'b1}} >> (FW - SIDE * SIDE);

    // Map a 1-based point through a clockwise rotation; returns {px, py}
    function automatic logic [7:0] map_point(input logic [3:0] px_in,
                                             input logic [3:0] py_in,
                                             input logic [1:0] rot);
        logic [3:0] mx;
        logic [3:0] my;
        case (rot)
            lmcf_pkg::ROT_90:
            begin
                mx = SIDE_C + 4'd1 - py_in;
                my = px_in;
            end
            lmcf_pkg::ROT_180:
            begin
                mx = SIDE_C + 4'd1 - px_in;
                my = SIDE_C + 4'd1 - py_in;
            end
            lmcf_pkg::ROT_270:
            begin
                mx = py_in;
                my = SIDE_C + 4'd1 - px_in;
            end
            default:
            begin
                mx = px_in;
                my = py_in;
            end
        endcase
        return {mx, my};
    endfunction

    // Bit position of a 1-based physical point
    function automatic logic [5:0] phys_index(input logic [7:0] p);
        logic [6:0] t;
        t = 7'(p[3:0] - 4'd1) * 7'(SIDE_C) + 7'(p[7:4] - 4'd1);
        return t[5:0];
    endfunction

    // One-hot frame mask of a logical point under the mounting rotation
    function automatic logic [FW-1:0] logical_bit(input logic [3:0] lx,
                                                 input logic [3:0] ly,
                                                 input logic [1:0] rot);
        logic [FW-1:0] b;
        b = '0;
        b[phys_index(map_point(lx, ly, rot))] = 1'b1;
        return b;
    endfunction

    // Move each row-major point of the square to its rotated position
    function automatic logic [FW-1:0] permute(input logic [FW-1:0] src,
                                             input logic [1:0] rot);
        logic [FW-1:0] res;
        res = '0;
        for (int r = 0; r < SIDE; r++)
        begin
            for (int c = 0; c < SIDE; c++)
            begin
                res[phys_index(map_point(4'(c + 1), 4'(r + 1), rot))] =
                    src[6'(r * SIDE + c)];
            end
        end
        return res;
    endfunction

    logic          coord_ok;
    logic [FW-1:0] item_bit;
    logic [FW-1:0] cur_bit;
    logic [FW-1:0] move_bit;
    logic [3:0]    move_x;
    logic [3:0]    move_y;
    logic [FW-1:0] work;

    // Decode coordinates and cursor masks
    always_comb
    begin
        coord_ok = (item.x >= 4'd1) && (item.x <= SIDE_C) &&
                   (item.y >= 4'd1) && (item.y <= SIDE_C);
        item_bit = logical_bit(item.x, item.y, orientation);
        cur_bit  = logical_bit(cur.cur_x, cur.cur_y, orientation);
    end

    // Step the cursor with wrap at the edges
    always_comb
    begin
        move_x = cur.cur_x;
        move_y = cur.cur_y;
        case (item.move_dir)
            lmcf_pkg::DIR_XP: move_x = (cur.cur_x >= SIDE_C) ? 4'd1 : cur.cur_x + 4'd1;
            lmcf_pkg::DIR_XN: move_x = (cur.cur_x <= 4'd1) ? SIDE_C : cur.cur_x - 4'd1;
            lmcf_pkg::DIR_YP: move_y = (cur.cur_y >= SIDE_C) ? 4'd1 : cur.cur_y + 4'd1;
            lmcf_pkg::DIR_YN: move_y = (cur.cur_y <= 4'd1) ? SIDE_C : cur.cur_y - 4'd1;
            default:
            begin
                move_x = cur.cur_x;
                move_y = cur.cur_y;
            end
        endcase
        move_bit = logical_bit(move_x, move_y, orientation);
    end

    // Execute the command
    always_comb
    begin
        nxt    = cur;
        status = lmcf_pkg::ST_NONE;
        work   = cur.pixels;
        case (item.cmd)
            lmcf_pkg::CMD_SET:
            begin
                if (coord_ok)
                    work = work | item_bit;
            end
            lmcf_pkg::CMD_CLEAR:
            begin
                if (coord_ok)
                    work = work & ~item_bit;
            end
            lmcf_pkg::CMD_TOGGLE:
            begin
                if (coord_ok)
                begin
                    work   = work ^ item_bit;
                    status = (|(work & item_bit)) ? lmcf_pkg::ST_ON : lmcf_pkg::ST_OFF;
                end
            end
            lmcf_pkg::CMD_GET:
            begin
                if (coord_ok)
                    status = (|(work & item_bit)) ? lmcf_pkg::ST_ON : lmcf_pkg::ST_OFF;
            end
            lmcf_pkg::CMD_LOAD:
            begin
                work = (work & ~REGION) | permute(item.image, orientation);
            end
            lmcf_pkg::CMD_ROTATE:
            begin
                work = permute(work, item.rotation);
            end
            lmcf_pkg::CMD_STAGE:
            begin
                if (coord_ok)
                begin
                    nxt.cur_x  = item.x;
                    nxt.cur_y  = item.y;
                    nxt.saved  = |(work & item_bit);
                    nxt.staged = 1'b1;
                end
            end
            lmcf_pkg::CMD_UNSTAGE:
            begin
                nxt.staged = 1'b0;
                work = cur.saved ? (work | cur_bit) : (work & ~cur_bit);
            end
            lmcf_pkg::CMD_TOGGLE_CUR:
            begin
                if (cur.staged)
                begin
                    nxt.staged = 1'b0;
                    work = cur.saved ? (work | cur_bit) : (work & ~cur_bit);
                end
                work   = work ^ cur_bit;
                status = (|(work & cur_bit)) ? lmcf_pkg::ST_ON : lmcf_pkg::ST_OFF;
            end
            lmcf_pkg::CMD_MOVE:
            begin
                // restore the old spot, then stage at the new one
                if (cur.staged)
                    work = cur.saved ? (work | cur_bit) : (work & ~cur_bit);
                nxt.cur_x  = move_x;
                nxt.cur_y  = move_y;
                nxt.saved  = |(work & move_bit);
                nxt.staged = 1'b1;
            end
            lmcf_pkg::CMD_TICK:
            begin
                nxt.blink = 1'b1;
            end
            lmcf_pkg::CMD_BLINK:
            begin
                if (cur.blink)
                begin
                    if (cur.staged)
                        work = work ^ cur_bit;
                    nxt.blink = 1'b0;
                end
            end
            lmcf_pkg::CMD_BLANK:
            begin
                work = '0;
            end
            default:
            begin
                work = cur.pixels;
            end
        endcase
        nxt.pixels = work;
    end

endmodule

[hw/rtl/led_matrix_cursor_framebuffer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_cursor_framebuffer_unit
// 8x8 one-bit LED frame buffer with rotation mapping and a blinking cursor.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------
//  input     | in_valid / in_stall  | cmd, x, y, move_dir, rotation, image
//  result    | out_valid / out_stall| point_status, frame
//  config    | cfg_valid / cfg_ready| cfg_data (orientation)
//
//  An item is held in the input register while the execute logic works on
//  it and is written to the result register once that register is free; the
//  input takes one item per cycle while the result is not stalled.
//  The frame and cursor state update in the same cycle the result is written.
//  Reset clears the frame, puts the cursor at (1,1) unstaged, orientation 0.
//  A stalled result holds the execute stage; with the input register full
//  too (two items held) the input stalls.
// ----------------------------------------------------------------------------
module led_matrix_cursor_framebuffer_unit #(
    parameter int SIDE = lmcf_pkg::SIDE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  cmd,
    input  logic [3:0]  x,
    input  logic [3:0]  y,
    input  logic [1:0]  move_dir,
    input  logic [1:0]  rotation,
    input  logic [63:0] image,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  point_status,
    output logic [63:0] frame,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data
);

    lmcf_pkg::item_t  item_reg;
    logic             item_valid_reg;
    lmcf_pkg::state_t state_reg;
    lmcf_pkg::state_t state_next;
    logic [1:0]       orient_reg;
    logic [1:0]       status_next;
    logic [1:0]       status_reg;
    logic [63:0]      frame_reg;
    logic             res_valid_reg;
    logic             res_free;
    logic             exec_go;
    logic             in_take;

    // Handshake control
    assign res_free  = !res_valid_reg || !out_stall;
    assign exec_go   = item_valid_reg && res_free;
    assign in_stall  = item_valid_reg && !res_free;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Hold the input item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_take)
            item_valid_reg <= 1'b1;
        else if (exec_go)
            item_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.cmd      <= cmd;
            item_reg.x        <= x;
            item_reg.y        <= y;
            item_reg.move_dir <= move_dir;
            item_reg.rotation <= rotation;
            item_reg.image    <= image;
        end
    end

    // Orientation register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            orient_reg <= lmcf_pkg::ROT_0;
        else if (cfg_valid && cfg_ready)
            orient_reg <= cfg_data;
    end

    lmcf_exec #(
        .SIDE (SIDE)
    ) u_exec (
        .cur         (state_reg),
        .item        (item_reg),
        .orientation (orient_reg),
        .nxt         (state_next),
        .status      (status_next)
    );

    // Advance frame and cursor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.pixels <= '0;
            state_reg.cur_x  <= 4'd1;
            state_reg.cur_y  <= 4'd1;
            state_reg.saved  <= 1'b0;
            state_reg.staged <= 1'b0;
            state_reg.blink  <= 1'b0;
        end
        else if (exec_go)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (exec_go)
            res_valid_reg <= 1'b1;
        else if (!out_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            status_reg <= status_next;
            frame_reg  <= state_next.pixels;
        end
    end

    assign out_valid    = res_valid_reg;
    assign point_status = status_reg;
    assign frame        = frame_reg;

endmodule
